// ===== sv/sba_pkg.sv =====
// Package with shared types and constants for the sample block average history block.
package sba_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WLEN_W     = 7;
  localparam int FILL_OUT_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SENTINEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SENTINEL = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RST = 7'd16;
  localparam logic [SAMPLE_W-1:0] LOW_SENTINEL_RST  = 16'd400;
  localparam logic [SAMPLE_W-1:0] HIGH_SENTINEL_RST = 16'd5000;

  // One result item.
  typedef struct packed {
    logic                  was_skipped;
    logic                  entry_stored;
    logic [SAMPLE_W-1:0]   stored_average;
    logic [FILL_OUT_W-1:0] fill_count;
    logic [SAMPLE_W-1:0]   history_max;
    logic [SAMPLE_W-1:0]   history_min;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic commit;
    logic scan;
    logic emit_item;
    logic emit_flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flush_needed;
    logic div_last;
    logic scan_last;
  } status_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIVIDE = 6'b000010,
    ST_COMMIT = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

endpackage

// ===== sv/sba_if.sv =====
// Valid/ready channel interfaces for the sample input and the result output.
interface sba_in_if import sba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface sba_out_if import sba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  was_skipped;
  logic                  entry_stored;
  logic [SAMPLE_W-1:0]   stored_average;
  logic [FILL_OUT_W-1:0] fill_count;
  logic [SAMPLE_W-1:0]   history_max;
  logic [SAMPLE_W-1:0]   history_min;

  modport source (
    output valid, output was_skipped, output entry_stored, output stored_average,
    output fill_count, output history_max, output history_min, input ready
  );
  modport sink (
    input valid, input was_skipped, input entry_stored, input stored_average,
    input fill_count, input history_max, input history_min, output ready
  );
endinterface

// ===== sv/sba_ctrl.sv =====
// Controller state machine that sequences accumulate, divide, commit and scan.
module sba_ctrl import sba_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    buf_free,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = buf_free;
        if (in_valid && buf_free) begin
          cmd.accept = 1'b1;
          if (status.flush_needed) begin
            state_next = ST_DIVIDE;
          end else begin
            cmd.emit_item = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (buf_free) begin
          cmd.emit_flush = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/sba_datapath.sv =====
// Datapath: configuration, window accumulator, serial divider, history ring and min/max scan.
module sba_datapath import sba_pkg::*; #(
  parameter int HISTORY_DEPTH = 64,
  parameter int MAX_WINDOW    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   sample_value,
  input  cmd_t                  cmd,
  output status_t               status,
  output result_t               result
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int DIVC_W = $clog2(SUM_W + 1);
  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  // Configuration registers.
  logic [WLEN_W-1:0]   window_length;
  logic [SAMPLE_W-1:0] low_sentinel;
  logic [SAMPLE_W-1:0] high_sentinel;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      low_sentinel  <= LOW_SENTINEL_RST;
      high_sentinel <= HIGH_SENTINEL_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WINDOW_LENGTH) begin
        window_length <= cfg_data[WLEN_W-1:0];
      end
      if (cfg_index == CFG_LOW_SENTINEL) begin
        low_sentinel <= cfg_data[SAMPLE_W-1:0];
      end
      if (cfg_index == CFG_HIGH_SENTINEL) begin
        high_sentinel <= cfg_data[SAMPLE_W-1:0];
      end
    end
  end

  // Window length clamped to 1..MAX_WINDOW.
  logic [CNT_W-1:0] eff_len;

  always_comb begin
    if (window_length == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(window_length);
    end
  end

  logic [SUM_W-1:0]  window_sum;
  logic [CNT_W-1:0]  window_count;
  logic              skip;
  logic              flush;

  assign skip  = (sample_value == low_sentinel) || (sample_value == high_sentinel);
  assign flush = !skip && !(window_count < eff_len);

  // Restoring divider, one quotient bit per cycle.
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [DIVC_W-1:0] div_cnt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [SAMPLE_W-1:0] avg;

  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = shifted - {1'b0, window_count};
  assign ge      = shifted >= {1'b0, window_count};
  assign avg     = (quo[SUM_W-1:SAMPLE_W] != '0) ? '1 : quo[SAMPLE_W-1:0];

  // History ring state.
  logic [ADDR_W-1:0]   write_slot;
  logic [FILL_W-1:0]   valid_entries;
  logic [SAMPLE_W-1:0] running_max;
  logic [SAMPLE_W-1:0] running_min;
  logic [ADDR_W-1:0]   scan_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_ok;
  logic                rd_live;
  logic [SAMPLE_W-1:0] history_mem [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum    <= '0;
      window_count  <= '0;
      write_slot    <= '0;
      valid_entries <= '0;
      running_max   <= LOW_SENTINEL_RST;
      running_min   <= HIGH_SENTINEL_RST;
      rd_live       <= 1'b0;
      div_cnt       <= '0;
    end else begin
      rd_live <= cmd.scan;
      if (cmd.accept && !skip) begin
        if (!flush) begin
          window_sum   <= window_sum + SUM_W'(sample_value);
          window_count <= window_count + CNT_W'(1);
        end else begin
          quo     <= window_sum;
          rem     <= '0;
          div_cnt <= DIVC_W'(SUM_W);
        end
      end
      if (cmd.div_step) begin
        quo     <= {quo[SUM_W-2:0], ge};
        rem     <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        div_cnt <= div_cnt - DIVC_W'(1);
      end
      if (cmd.commit) begin
        window_sum   <= '0;
        window_count <= '0;
        if (write_slot == ADDR_W'(HISTORY_DEPTH - 1)) begin
          write_slot <= '0;
        end else begin
          write_slot <= write_slot + ADDR_W'(1);
        end
        if (valid_entries != FILL_W'(HISTORY_DEPTH)) begin
          valid_entries <= valid_entries + FILL_W'(1);
        end
        running_max <= low_sentinel;
        running_min <= high_sentinel;
        scan_addr   <= '0;
      end
      if (cmd.scan) begin
        scan_addr <= scan_addr + ADDR_W'(1);
        rd_ok     <= FILL_W'(scan_addr) < valid_entries;
      end
      // Slots at or past the fill count were never written and count as empty.
      if (rd_live && rd_ok && rd_data != '0) begin
        if (rd_data > running_max) begin
          running_max <= rd_data;
        end
        if (rd_data < running_min) begin
          running_min <= rd_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      history_mem[write_slot] <= avg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= history_mem[scan_addr];
    end
  end

  assign status.flush_needed = flush;
  assign status.div_last     = div_cnt == DIVC_W'(1);
  assign status.scan_last    = scan_addr == ADDR_W'(HISTORY_DEPTH - 1);

  logic [FILL_W+FILL_OUT_W-1:0] fill_ext;
  assign fill_ext = {{FILL_OUT_W{1'b0}}, valid_entries};

  always_comb begin
    result.was_skipped    = cmd.emit_item && skip;
    result.entry_stored   = cmd.emit_flush;
    result.stored_average = cmd.emit_flush ? avg : '0;
    result.fill_count     = fill_ext[FILL_OUT_W-1:0];
    result.history_max    = running_max;
    result.history_min    = running_min;
  end

endmodule

// ===== sv/sba_outbuf.sv =====
// Two-entry output buffer that drives the result channel.
module sba_outbuf import sba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  result_t     push_data,
  output logic        buf_free,
  sba_out_if.source   out_ch
);

  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    pop;

  assign pop      = out_valid && out_ch.ready;
  assign buf_free = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= push;
        skid_data  <= push_data;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (!out_valid) begin
      out_valid <= push;
      out_data  <= push_data;
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.was_skipped    = out_data.was_skipped;
  assign out_ch.entry_stored   = out_data.entry_stored;
  assign out_ch.stored_average = out_data.stored_average;
  assign out_ch.fill_count     = out_data.fill_count;
  assign out_ch.history_max    = out_data.history_max;
  assign out_ch.history_min    = out_data.history_min;

endmodule

// ===== sv/sample_block_average_history_top.sv =====
// Top level of the block-average decimator with a min/max history ring.
//
// Each sample transfer on in_ch yields exactly one result transfer on out_ch. A sample
// equal to the low or high sentinel is skipped and changes no state. Other samples are
// summed into a window until the window holds window_length samples (zero is treated as
// one, values above MAX_WINDOW as MAX_WINDOW). The next non-sentinel sample is not
// summed; it writes the truncated window average into the history ring, grows the fill
// count up to HISTORY_DEPTH, and rescans the ring for the largest and smallest nonzero
// entries, starting from the current sentinels. A skipped or summed sample pushes its
// result as it transfers. A flushing sample steps through the divide, commit, scan, drain
// and done states and takes no new sample meanwhile: the serial divider yields one
// quotient bit per cycle and the single-read-port history memory is swept one entry per
// cycle. Results pass through a two-entry output buffer, so a sample can be taken while a
// result waits on out_ch. History slots that were never written are recognized from the
// fill count and read as empty, so no clearing pass is needed after reset. Configuration
// writes take effect on the next cycle and should only be made while the block is idle.
module sample_block_average_history_top import sba_pkg::*; #(
  parameter int HISTORY_DEPTH = 64,
  parameter int MAX_WINDOW    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sba_in_if.sink                in_ch,
  sba_out_if.source             out_ch
);

  cmd_t    cmd;
  status_t status;
  result_t result;
  logic    buf_free;
  logic    res_push;

  // The controller owns the input handshake and steps the datapath through a flush.
  sba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .buf_free (buf_free),
    .status   (status),
    .cmd      (cmd)
  );

  sba_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_WINDOW    (MAX_WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_value (in_ch.sample_value),
    .cmd          (cmd),
    .status       (status),
    .result       (result)
  );

  // A result is pushed either in the cycle its sample transfers or when a flush finishes.
  assign res_push = cmd.emit_item || cmd.emit_flush;

  sba_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (result),
    .buf_free  (buf_free),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // The output buffer must never be pushed while its spare entry is occupied.
  assert property (@(posedge clk) disable iff (rst) res_push |-> buf_free)
    else $error("result pushed into a full output buffer");

  // A sample that starts a flush produces no result in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && status.flush_needed) |=> !res_push)
    else $error("result pushed while a flush is in progress");

  // A stored entry is never reported as a skipped sample.
  assert property (@(posedge clk) disable iff (rst)
    res_push |-> !(result.was_skipped && result.entry_stored))
    else $error("result both skipped and stored");
`endif

endmodule

// ===== dv/sample_block_average_history_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the block-average decimator: directed and random tests against a local predictor.
module sample_block_average_history_top_tb;
  import sba_pkg::*;

  // Parameters of the block under test, kept at their defaults.
  localparam int RING_DEPTH = 64;
  localparam int MAX_WINDOW = 64;

  // Random traffic starts no new phase once this many samples have been transferred.
  localparam int ITEM_TARGET = 1350;

  // The watchdog ends the run after this many cycles without any transfer or register
  // write, many times longer than a flush, the longest sender gap or a single stretch
  // of ready held low by the receiver.
  localparam int WATCHDOG_LIMIT = 4000;

  // Cycles to wait once everything has been checked, about one flush of the block.
  localparam int DRAIN_CYCLES = 100;

  // Stall patterns of the result receiver.
  typedef enum int {RX_STEADY, RX_RANDOM, RX_HOLD, RX_SPARSE} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sba_in_if  in_ch ();
  sba_out_if out_ch ();

  sample_block_average_history_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Copy of the block's registers, as last written through the configuration port.
  logic [WLEN_W-1:0]   reg_wlen;
  logic [SAMPLE_W-1:0] reg_low;
  logic [SAMPLE_W-1:0] reg_high;

  // Predicted block state: the open window, the history ring and the scan results.
  logic [21:0]         win_total;
  logic [WLEN_W-1:0]   win_seen;
  logic [SAMPLE_W-1:0] avg_ring [RING_DEPTH];
  int                  ring_wr;
  int                  ring_used;
  logic [SAMPLE_W-1:0] peak_max;
  logic [SAMPLE_W-1:0] peak_min;

  // Results predicted for transferred samples that have not come out yet, oldest first.
  result_t pending_results [$];

  int errors;
  int samples_sent;
  int burst_left;

  // Clock with a 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The window length actually in force: zero acts as one, and anything above the
  // largest window is clamped to it.
  function automatic logic [WLEN_W-1:0] window_target();
    if (reg_wlen == '0) return WLEN_W'(1);
    if (reg_wlen > MAX_WINDOW) return WLEN_W'(MAX_WINDOW);
    return reg_wlen;
  endfunction

  // Works out the result of one sample and advances the predicted state. A sentinel
  // touches nothing. While the window is short of its length the sample is summed.
  // Otherwise this sample is dropped and instead closes the window: the truncated
  // average goes into the ring and the whole ring is rescanned, with zero entries
  // counting as empty and the scan starting from the sentinels as they stand now.
  function automatic result_t predict_sample(input logic [SAMPLE_W-1:0] value);
    result_t    res;
    logic [21:0] avg;
    res = '0;
    if (value == reg_low || value == reg_high) begin
      res.was_skipped = 1'b1;
    end else if (win_seen < window_target()) begin
      win_total = win_total + value;
      win_seen  = win_seen + 1'b1;
    end else begin
      // The count here is at least one, and a true average never leaves 16 bits.
      avg = win_total / win_seen;
      avg_ring[ring_wr] = avg[SAMPLE_W-1:0];
      ring_wr = (ring_wr == RING_DEPTH - 1) ? 0 : ring_wr + 1;
      if (ring_used < RING_DEPTH) ring_used++;
      win_total = '0;
      win_seen  = '0;
      res.entry_stored   = 1'b1;
      res.stored_average = avg[SAMPLE_W-1:0];
      peak_max = reg_low;
      peak_min = reg_high;
      foreach (avg_ring[i]) begin
        if (avg_ring[i] != '0) begin
          if (avg_ring[i] > peak_max) peak_max = avg_ring[i];
          if (avg_ring[i] < peak_min) peak_min = avg_ring[i];
        end
      end
    end
    res.fill_count  = FILL_OUT_W'(ring_used);
    res.history_max = peak_max;
    res.history_min = peak_min;
    return res;
  endfunction

  // Sends one sample and records its predicted result once the transfer happens. The
  // sender works in bursts; when one runs out, valid may drop for a random gap that is
  // usually short and now and then long enough to cover a whole flush. Valid stays high
  // between samples of a burst, so it is never lowered and raised in the same step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    int pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 88) gap = $urandom_range(1, 4);
      else gap = $urandom_range(5, 120);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    samples_sent++;
    pending_results.push_back(predict_sample(value));
  endtask

  // Stops sending and waits until every predicted result has been checked. Each sample
  // gives exactly one result, so the block is idle once nothing is pending.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the predictor picks up the new value at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW_LENGTH: reg_wlen = data[WLEN_W-1:0];
      CFG_LOW_SENTINEL:  reg_low  = data;
      CFG_HIGH_SENTINEL: reg_high = data;
      default: ;
    endcase
  endtask

  // Waits for the block to go idle, then writes all three registers.
  task automatic set_config(input logic [WLEN_W-1:0] wlen,
                            input logic [SAMPLE_W-1:0] low,
                            input logic [SAMPLE_W-1:0] high);
    wait_idle();
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(wlen));
    write_reg(CFG_LOW_SENTINEL, low);
    write_reg(CFG_HIGH_SENTINEL, high);
    // Writes take effect on the next cycle; give them that before new samples arrive.
    repeat (2) @(posedge clk);
  endtask

  // Random sample with a bias toward the interesting values: both sentinels, the
  // extremes of the field, values just around the low sentinel and small readings.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return reg_low;
    if (pick < 24) return reg_high;
    if (pick < 30) return '0;
    if (pick < 36) return '1;
    if (pick < 60) return SAMPLE_W'($urandom_range(0, 65535));
    if (pick < 80) return SAMPLE_W'(reg_low + $urandom_range(0, 8) - 4);
    return SAMPLE_W'($urandom_range(1, 2000));
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Result checker: every transfer on the output channel is matched against the oldest
  // pending prediction, field by field.
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no sample waiting for it");
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("was_skipped", want.was_skipped, out_ch.was_skipped);
          compare_field("entry_stored", want.entry_stored, out_ch.entry_stored);
          compare_field("stored_average", want.stored_average, out_ch.stored_average);
          compare_field("fill_count", want.fill_count, out_ch.fill_count);
          compare_field("history_max", want.history_max, out_ch.history_max);
          compare_field("history_min", want.history_min, out_ch.history_min);
        end
      end
    end
  end

  // Result receiver. Ready follows one pattern for a random stretch and then switches:
  // always ready, a coin toss per cycle, held low, or high only a quarter of the time.
  initial begin
    rx_mode_t mode;
    int       span;
    out_ch.ready <= 1'b0;
    mode = RX_STEADY;
    span = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = (mode == RX_HOLD) ? $urandom_range(1, 60) : $urandom_range(5, 60);
      end
      span--;
      case (mode)
        RX_STEADY: out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
        RX_HOLD:   out_ch.ready <= 1'b0;
        default:   out_ch.ready <= (span % 4 == 0);
      endcase
    end
  end

  // Watchdog: any transfer or register write restarts the count of quiet cycles.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // With the reset configuration, both sentinels are skipped and the field extremes
  // are summed into the default 16-sample window without closing it.
  task automatic test_sentinel_skip();
    send_sample(LOW_SENTINEL_RST);
    send_sample(HIGH_SENTINEL_RST);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
  endtask

  // Length one and length zero (which acts as one). Lowering the length to one with
  // three samples already in the window makes the next sample flush at once, and the
  // average is taken over all three. A window of zeros stores an average of zero, which
  // the scan must treat as an empty slot.
  task automatic test_short_windows();
    set_config(WLEN_W'(1), LOW_SENTINEL_RST, HIGH_SENTINEL_RST);
    send_sample(16'd2);
    send_sample(16'hFFFF);
    send_sample(16'd9);
    send_sample(16'd0);
    send_sample(16'd9);
    set_config(WLEN_W'(0), LOW_SENTINEL_RST, HIGH_SENTINEL_RST);
    send_sample(16'd3);
    send_sample(16'd4);
  endtask

  // Rewritten sentinels: the reported max and min keep their old values until the next
  // flush restarts the scan. Equal sentinels skip one value, and sentinels at the field
  // extremes make zero and full scale unusable as samples.
  task automatic test_sentinel_rewrite();
    set_config(WLEN_W'(1), 16'd777, 16'd777);
    send_sample(16'd777);
    send_sample(16'd300);
    send_sample(16'd500);
    set_config(WLEN_W'(1), 16'h0000, 16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'd10);
    send_sample(16'd20);
  endtask

  // The length is cut below the number of samples already in the window; the next
  // sample flushes the whole window.
  task automatic test_window_shrink();
    set_config(WLEN_W'(8), LOW_SENTINEL_RST, HIGH_SENTINEL_RST);
    send_sample(16'd1000);
    send_sample(16'd2000);
    send_sample(16'd3001);
    send_sample(16'd65535);
    send_sample(16'd17);
    set_config(WLEN_W'(2), LOW_SENTINEL_RST, HIGH_SENTINEL_RST);
    send_sample(16'd42);
  endtask

  // A length above the largest window saturates; the full 64-sample window is filled
  // with random readings, mostly large, to push the sum toward its widest.
  task automatic test_window_saturation();
    set_config(WLEN_W'(127), LOW_SENTINEL_RST, HIGH_SENTINEL_RST);
    repeat (150) begin
      if ($urandom_range(0, 3) == 0) send_sample(pick_sample());
      else send_sample(SAMPLE_W'($urandom_range(60000, 65535)));
    end
  endtask

  // Random phases, each with its own configuration written while idle. Short windows
  // dominate so the ring fills, wraps and is rescanned many times; some phases use
  // length zero, the largest window or lengths beyond it. Each new phase starts by
  // waiting for all pending results, so the sender regularly pauses until drained.
  task automatic test_random_traffic();
    int                  pick;
    int                  count;
    logic [WLEN_W-1:0]   wlen;
    logic [SAMPLE_W-1:0] low;
    logic [SAMPLE_W-1:0] high;
    while (samples_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) wlen = WLEN_W'($urandom_range(1, 6));
      else if (pick < 75) wlen = WLEN_W'($urandom_range(7, 20));
      else if (pick < 85) wlen = '0;
      else if (pick < 92) wlen = WLEN_W'(MAX_WINDOW);
      else wlen = WLEN_W'($urandom_range(65, 127));

      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        low  = LOW_SENTINEL_RST;
        high = HIGH_SENTINEL_RST;
      end else if (pick < 40) begin
        low  = SAMPLE_W'($urandom_range(0, 65535));
        high = low;
      end else if (pick < 50) begin
        low  = '0;
        high = '1;
      end else if (pick < 58) begin
        low  = '1;
        high = '0;
      end else begin
        low  = SAMPLE_W'($urandom_range(0, 65535));
        high = SAMPLE_W'($urandom_range(0, 65535));
      end

      set_config(wlen, low, high);
      count = (window_target() >= 20) ? $urandom_range(80, 200) : $urandom_range(20, 80);
      repeat (count) send_sample(pick_sample());
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_WINDOW_LENGTH;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.sample_value <= '0;

    // Predictor starts from the reset state of the block.
    reg_wlen  = WINDOW_LENGTH_RST;
    reg_low   = LOW_SENTINEL_RST;
    reg_high  = HIGH_SENTINEL_RST;
    win_total = '0;
    win_seen  = '0;
    foreach (avg_ring[i]) avg_ring[i] = '0;
    ring_wr      = 0;
    ring_used    = 0;
    peak_max     = LOW_SENTINEL_RST;
    peak_min     = HIGH_SENTINEL_RST;
    errors       = 0;
    samples_sent = 0;
    burst_left   = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sentinel_skip();
    test_short_windows();
    test_sentinel_rewrite();
    test_window_shrink();
    test_window_saturation();
    test_random_traffic();

    // Drain everything, then give the block one more flush worth of cycles to show
    // any result it should not produce.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
